### design/jbhp_pkg.sv
// Shared types and constants for the JPEG baseline header parser.
`default_nettype none
package jbhp_pkg;

  localparam logic [7:0] MARKER_PREFIX = 8'hff;
  localparam logic [7:0] MARKER_SOI    = 8'hd8;
  localparam logic [7:0] MARKER_SOF0   = 8'hc0;

  localparam logic [7:0] NCOMP_GRAY = 8'd1;
  localparam logic [7:0] NCOMP_RGB  = 8'd3;
  localparam logic [7:0] NCOMP_CMYK = 8'd4;

  localparam logic [15:0] MIN_SEG_LEN = 16'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADSTART = 3'd1,
    ST_NOPREFIX = 3'd2,
    ST_COMPS    = 3'd3,
    ST_SHORTLEN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CS_GRAY = 2'd0,
    CS_RGB  = 2'd1,
    CS_CMYK = 2'd2
  } color_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SOI2,
    PH_PREFIX,
    PH_MARKER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_FRAME
  } phase_t;

  localparam logic [3:0] FRM_LEN_HI = 4'd0;
  localparam logic [3:0] FRM_LEN_LO = 4'd1;
  localparam logic [3:0] FRM_PREC   = 4'd2;
  localparam logic [3:0] FRM_H_HI   = 4'd3;
  localparam logic [3:0] FRM_H_LO   = 4'd4;
  localparam logic [3:0] FRM_W_HI   = 4'd5;
  localparam logic [3:0] FRM_W_LO   = 4'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [7:0]  bits_per_component;
    logic [1:0]  color_space;
  } out_t;

endpackage
`default_nettype wire

### design/jbhp_in_stage.sv
// Input register stage holding one accepted byte request.
`default_nettype none
module jbhp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire jbhp_pkg::in_t in_req,
  output      logic          item_vld,
  output      jbhp_pkg::in_t item,
  input  wire logic          take
);

  logic          vld_r;
  logic          vld_nxt;
  jbhp_pkg::in_t req_r;
  logic          load;

  assign in_stall = vld_r & ~take;
  assign load     = in_valid & ~in_stall;
  assign item_vld = vld_r;
  assign item     = req_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_req;
    end
  end

endmodule
`default_nettype wire

### design/jbhp_parser.sv
// Marker walk state machine, frame field capture and result register.
`default_nettype none
module jbhp_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_vld,
  input  wire jbhp_pkg::in_t  item,
  output      logic           take,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      jbhp_pkg::out_t out_res
);

  jbhp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      skip_r, skip_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [15:0]      height_r, height_nxt;
  logic [15:0]      width_r, width_nxt;
  logic [7:0]       prec_r, prec_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic             out_vld_r, out_vld_nxt;
  jbhp_pkg::out_t   res_r, res_nxt;
  logic             emit;

  logic [7:0]  b;
  logic [15:0] seg_len;
  logic        short_len;
  logic [15:0] skip_len;

  assign take      = item_vld & ~(out_vld_r & out_stall);
  assign b         = item.data_byte;
  assign seg_len   = {len_hi_r, b};
  assign short_len = seg_len < jbhp_pkg::MIN_SEG_LEN;
  assign skip_len  = seg_len - jbhp_pkg::MIN_SEG_LEN;

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (item.first_byte) begin
        phase_nxt = (b == jbhp_pkg::MARKER_PREFIX) ? jbhp_pkg::PH_SOI2 : jbhp_pkg::PH_IDLE;
      end else begin
        unique case (phase_r)
          jbhp_pkg::PH_SOI2: begin
            phase_nxt = (b == jbhp_pkg::MARKER_SOI) ? jbhp_pkg::PH_PREFIX : jbhp_pkg::PH_IDLE;
          end
          jbhp_pkg::PH_PREFIX: begin
            phase_nxt = (b == jbhp_pkg::MARKER_PREFIX) ? jbhp_pkg::PH_MARKER
                                                       : jbhp_pkg::PH_IDLE;
          end
          jbhp_pkg::PH_MARKER: begin
            phase_nxt = (b == jbhp_pkg::MARKER_SOF0) ? jbhp_pkg::PH_FRAME
                                                     : jbhp_pkg::PH_LEN_HI;
          end
          jbhp_pkg::PH_LEN_HI: begin
            phase_nxt = jbhp_pkg::PH_LEN_LO;
          end
          jbhp_pkg::PH_LEN_LO: begin
            if (short_len) begin
              phase_nxt = jbhp_pkg::PH_IDLE;
            end else if (skip_len == 16'd0) begin
              phase_nxt = jbhp_pkg::PH_PREFIX;
            end else begin
              phase_nxt = jbhp_pkg::PH_SKIP;
            end
          end
          jbhp_pkg::PH_SKIP: begin
            if (skip_r == 16'd1) begin
              phase_nxt = jbhp_pkg::PH_PREFIX;
            end
          end
          jbhp_pkg::PH_FRAME: begin
            if (idx_r == jbhp_pkg::FRM_LEN_LO && short_len) begin
              phase_nxt = jbhp_pkg::PH_IDLE;
            end else if (idx_r > jbhp_pkg::FRM_W_LO) begin
              phase_nxt = jbhp_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_nxt = jbhp_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    skip_nxt   = skip_r;
    idx_nxt    = idx_r;
    height_nxt = height_r;
    width_nxt  = width_r;
    prec_nxt   = prec_r;
    len_hi_nxt = len_hi_r;
    emit       = 1'b0;
    res_nxt    = '0;
    if (take) begin
      if (item.first_byte) begin
        idx_nxt  = 4'd0;
        skip_nxt = 16'd0;
        if (b != jbhp_pkg::MARKER_PREFIX) begin
          emit           = 1'b1;
          res_nxt.status = jbhp_pkg::ST_BADSTART;
        end
      end else begin
        unique case (phase_r)
          jbhp_pkg::PH_SOI2: begin
            if (b != jbhp_pkg::MARKER_SOI) begin
              emit           = 1'b1;
              res_nxt.status = jbhp_pkg::ST_BADSTART;
            end
          end
          jbhp_pkg::PH_PREFIX: begin
            if (b != jbhp_pkg::MARKER_PREFIX) begin
              emit           = 1'b1;
              res_nxt.status = jbhp_pkg::ST_NOPREFIX;
            end
          end
          jbhp_pkg::PH_MARKER: begin
            if (b == jbhp_pkg::MARKER_SOF0) begin
              idx_nxt = 4'd0;
            end
          end
          jbhp_pkg::PH_LEN_HI: begin
            len_hi_nxt = b;
          end
          jbhp_pkg::PH_LEN_LO: begin
            if (short_len) begin
              emit           = 1'b1;
              res_nxt.status = jbhp_pkg::ST_SHORTLEN;
            end else begin
              skip_nxt = skip_len;
            end
          end
          jbhp_pkg::PH_SKIP: begin
            skip_nxt = skip_r - 16'd1;
          end
          jbhp_pkg::PH_FRAME: begin
            idx_nxt = idx_r + 4'd1;
            unique case (idx_r)
              jbhp_pkg::FRM_LEN_HI: len_hi_nxt = b;
              jbhp_pkg::FRM_LEN_LO: begin
                if (short_len) begin
                  emit           = 1'b1;
                  res_nxt.status = jbhp_pkg::ST_SHORTLEN;
                  idx_nxt        = idx_r;
                end
              end
              jbhp_pkg::FRM_PREC: prec_nxt   = b;
              jbhp_pkg::FRM_H_HI: height_nxt = {b, 8'd0};
              jbhp_pkg::FRM_H_LO: height_nxt = {height_r[15:8], b};
              jbhp_pkg::FRM_W_HI: width_nxt  = {b, 8'd0};
              jbhp_pkg::FRM_W_LO: width_nxt  = {width_r[15:8], b};
              default: begin
                idx_nxt = 4'd0;
                emit    = 1'b1;
                if (b == jbhp_pkg::NCOMP_GRAY || b == jbhp_pkg::NCOMP_RGB ||
                    b == jbhp_pkg::NCOMP_CMYK) begin
                  res_nxt.status             = jbhp_pkg::ST_OK;
                  res_nxt.image_height       = height_r;
                  res_nxt.image_width        = width_r;
                  res_nxt.bits_per_component = prec_r;
                  if (b == jbhp_pkg::NCOMP_GRAY) begin
                    res_nxt.color_space = jbhp_pkg::CS_GRAY;
                  end else if (b == jbhp_pkg::NCOMP_RGB) begin
                    res_nxt.color_space = jbhp_pkg::CS_RGB;
                  end else begin
                    res_nxt.color_space = jbhp_pkg::CS_CMYK;
                  end
                end else begin
                  res_nxt.status = jbhp_pkg::ST_COMPS;
                end
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_stall) begin
      out_vld_nxt = out_vld_r;
    end else begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= jbhp_pkg::PH_IDLE;
      skip_r    <= 16'd0;
      idx_r     <= 4'd0;
      height_r  <= 16'd0;
      width_r   <= 16'd0;
      prec_r    <= 8'd0;
      len_hi_r  <= 8'd0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      idx_r     <= idx_nxt;
      height_r  <= height_nxt;
      width_r   <= width_nxt;
      prec_r    <= prec_nxt;
      len_hi_r  <= len_hi_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

### design/jpeg_baseline_header_parser_core.sv
// Top level of the JPEG baseline header parser.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   input    | in_valid / in_stall  | in_req  (data_byte, first_byte)
//   result   | out_valid / out_stall| out_res (status, size, precision, color)
//
// One byte request is taken every cycle unless a held result is stalled; the
// completing byte passes the input register and then the result is written
// to the output register. Throughput is set by the input register and the
// parser step. Reset clears the valid bits and returns the parser to idle. A
// stalled result holds while the input register still takes one more byte.
`default_nettype none
module jpeg_baseline_header_parser_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output      logic           in_stall,
  input  wire jbhp_pkg::in_t  in_req,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      jbhp_pkg::out_t out_res
);

  logic          item_vld;
  jbhp_pkg::in_t item;
  logic          take;

  jbhp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .item_vld (item_vld),
    .item     (item),
    .take     (take)
  );

  jbhp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire
